// File: hdl/bfd_pkg.sv
// Shared types, codes and CRC functions for the bus frame field decoder.
package bfd_pkg;

    // Link event codes carried on the action field.
    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_DATA  = 2'd1;
    localparam logic [1:0] ACT_SYNC  = 2'd2;
    localparam logic [1:0] ACT_IDLE  = 2'd3;

    // Field kinds; the parse step of a frame uses the same codes.
    localparam logic [3:0] KIND_RX_ID    = 4'd0;
    localparam logic [3:0] KIND_HEADER   = 4'd1;
    localparam logic [3:0] KIND_LENGTH   = 4'd2;
    localparam logic [3:0] KIND_META_CRC = 4'd3;
    localparam logic [3:0] KIND_RX_BUS   = 4'd4;
    localparam logic [3:0] KIND_TX_BUS   = 4'd5;
    localparam logic [3:0] KIND_TX_ID    = 4'd6;
    localparam logic [3:0] KIND_SERVICE  = 4'd7;
    localparam logic [3:0] KIND_PACKET   = 4'd8;
    localparam logic [3:0] KIND_PAYLOAD  = 4'd9;
    localparam logic [3:0] KIND_END_CRC  = 4'd10;
    localparam logic [3:0] KIND_ACK      = 4'd11;

    // CRC constants.
    localparam logic [7:0]  CRC8_POLY  = 8'h97;
    localparam logic [31:0] CRC32_POLY = 32'hedb88320;
    localparam logic [31:0] CRC32_INIT = 32'hffffffff;

    // Largest length field value that a CRC8 frame should carry.
    localparam logic [15:0] CRC8_MAX_LEN = 16'd15;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_COLLECT,
        MODE_ACK
    } t_link_mode;

    // One decoded field, as handed to the output register.
    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] value;
        logic        last;
        logic [7:0]  warn;
        logic [31:0] crc;
    } t_result;

    // Reflected CRC8 update over one byte.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC8_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Reflected CRC32 update over one byte.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC32_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Whether an optional field is carried by the frame.
    function automatic logic step_present(input logic [3:0] step, input logic [7:0] flags,
                                          input logic plen_nz);
        logic p;
        case (step)
            KIND_RX_BUS:  p = flags[0];
            KIND_TX_BUS:  p = flags[0] & flags[1];
            KIND_TX_ID:   p = flags[1];
            KIND_SERVICE: p = flags[4];
            KIND_PACKET:  p = flags[7];
            KIND_PAYLOAD: p = plen_nz;
            default:      p = 1'b1;
        endcase
        return p;
    endfunction

    // First field after the current one that the frame carries.
    function automatic logic [3:0] next_step(input logic [3:0] step, input logic [7:0] flags,
                                             input logic plen_nz);
        logic [3:0] s;
        logic       found;
        s = KIND_END_CRC;
        found = 1'b0;
        for (int k = 1; k < 10; k++) begin
            if (!found && (4'(k) > step) && step_present(4'(k), flags, plen_nz)) begin
                s = 4'(k);
                found = 1'b1;
            end
        end
        return s;
    endfunction

endpackage

// File: hdl/bfd_core.sv
// Frame state and per-byte field decode logic of the bus frame field decoder.
module bfd_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [1:0]        i_action,
    input  logic [7:0]        i_data_byte,
    output logic              o_res_valid,
    output bfd_pkg::t_result  o_res
);

    bfd_pkg::t_link_mode r_mode, n_mode;
    logic [3:0]  r_step, n_step;
    logic [15:0] r_bytes, n_bytes;
    logic [31:0] r_shift, n_shift;
    logic [7:0]  r_flags, n_flags;
    logic [15:0] r_plen, n_plen;
    logic [7:0]  r_rx_id, n_rx_id;
    logic [7:0]  r_crc8, n_crc8;
    logic [31:0] r_crc32, n_crc32;
    logic [31:0] r_snap, n_snap;
    logic        r_done, n_done;

    logic [15:0] bytes_new;
    logic [31:0] shift_new;
    logic [7:0]  crc8_new;
    logic [31:0] crc32_new;
    logic [31:0] snap_now;
    logic [15:0] width;
    logic [15:0] len;
    logic [4:0]  ovh;
    logic [15:0] ovh16;
    logic [15:0] plen_calc;
    logic        ack_req;
    logic [7:0]  adv_flags;
    logic        adv_plen_nz;
    logic [3:0]  adv_step;

    // Values that every data byte of a frame produces.
    always_comb begin
        bytes_new = r_bytes + 16'd1;
        shift_new = {r_shift[23:0], i_data_byte};
        crc8_new  = bfd_pkg::crc8_byte(r_crc8, i_data_byte);
        crc32_new = bfd_pkg::crc32_byte(r_crc32, i_data_byte);
        snap_now  = (r_bytes == 16'd0) ? (r_crc32 ^ bfd_pkg::CRC32_INIT) : r_snap;
        ack_req   = i_data_byte[2] | i_data_byte[3];
    end

    // Byte count of the current field.
    always_comb begin
        case (r_step)
            bfd_pkg::KIND_LENGTH:  width = r_flags[6] ? 16'd2 : 16'd1;
            bfd_pkg::KIND_RX_BUS:  width = 16'd4;
            bfd_pkg::KIND_TX_BUS:  width = 16'd4;
            bfd_pkg::KIND_SERVICE: width = 16'd2;
            bfd_pkg::KIND_PACKET:  width = 16'd2;
            bfd_pkg::KIND_PAYLOAD: width = r_plen;
            bfd_pkg::KIND_END_CRC: width = r_flags[5] ? 16'd4 : 16'd1;
            default:               width = 16'd1;
        endcase
    end

    // Length field and frame overhead.
    always_comb begin
        len = r_flags[6] ? shift_new[15:0] : {8'd0, shift_new[7:0]};
        ovh = 5'd3 + (r_flags[6] ? 5'd2 : 5'd1)
            + (r_flags[0] ? 5'd4 : 5'd0)
            + (r_flags[1] ? (r_flags[0] ? 5'd5 : 5'd1) : 5'd0)
            + (r_flags[4] ? 5'd2 : 5'd0)
            + (r_flags[7] ? 5'd2 : 5'd0)
            + (r_flags[5] ? 5'd4 : 5'd1);
        ovh16 = {11'd0, ovh};
        plen_calc = (len <= ovh16) ? 16'd0 : (len - ovh16);
    end

    // Next field step; header and length bytes set what follows.
    always_comb begin
        adv_flags   = (r_step == bfd_pkg::KIND_HEADER) ? i_data_byte : r_flags;
        adv_plen_nz = (r_step == bfd_pkg::KIND_LENGTH) ? (plen_calc != 16'd0)
                                                       : (r_plen != 16'd0);
        adv_step    = bfd_pkg::next_step(r_step, adv_flags, adv_plen_nz);
    end

    // Link mode follows the link events.
    always_comb begin
        n_mode = r_mode;
        if (i_fire) begin
            case (i_action)
                bfd_pkg::ACT_START: n_mode = bfd_pkg::MODE_COLLECT;
                bfd_pkg::ACT_SYNC:  n_mode = bfd_pkg::MODE_ACK;
                bfd_pkg::ACT_IDLE:  n_mode = bfd_pkg::MODE_IDLE;
                default:            n_mode = r_mode;
            endcase
        end
    end

    // Frame state update and result of one transaction.
    always_comb begin
        n_step  = r_step;
        n_bytes = r_bytes;
        n_shift = r_shift;
        n_flags = r_flags;
        n_plen  = r_plen;
        n_rx_id = r_rx_id;
        n_crc8  = r_crc8;
        n_crc32 = r_crc32;
        n_snap  = r_snap;
        n_done  = r_done;
        o_res_valid = 1'b0;
        o_res = '0;
        if (i_fire) begin
            if (i_action == bfd_pkg::ACT_START || i_action == bfd_pkg::ACT_IDLE) begin
                n_step  = '0;
                n_bytes = '0;
                n_shift = '0;
                n_flags = '0;
                n_plen  = '0;
                n_rx_id = '0;
                n_crc8  = '0;
                n_crc32 = bfd_pkg::CRC32_INIT;
                n_snap  = '0;
                n_done  = 1'b0;
            end else if (i_action == bfd_pkg::ACT_DATA) begin
                if (r_mode == bfd_pkg::MODE_ACK) begin
                    o_res_valid = 1'b1;
                    o_res.kind  = bfd_pkg::KIND_ACK;
                    o_res.value = {24'd0, i_data_byte};
                    o_res.last  = 1'b1;
                end else if (r_mode == bfd_pkg::MODE_COLLECT && !r_done
                             && r_step <= bfd_pkg::KIND_END_CRC) begin
                    // Running CRCs cover every byte ahead of the end CRC.
                    if (r_step == bfd_pkg::KIND_END_CRC) begin
                        n_snap = snap_now;
                    end else begin
                        n_crc8  = crc8_new;
                        n_crc32 = crc32_new;
                    end
                    n_shift = shift_new;
                    n_bytes = bytes_new;

                    if (r_step == bfd_pkg::KIND_PAYLOAD || bytes_new >= width) begin
                        o_res_valid = 1'b1;
                        o_res.kind  = r_step;
                        o_res.value = shift_new;
                        o_res.last  = 1'b1;
                        case (r_step)
                            bfd_pkg::KIND_RX_ID: begin
                                n_rx_id = i_data_byte;
                            end
                            bfd_pkg::KIND_HEADER: begin
                                n_flags = i_data_byte;
                                o_res.warn[0] = ack_req & ~i_data_byte[1];
                                o_res.warn[1] = ack_req & (r_rx_id == 8'd0);
                                o_res.warn[2] = i_data_byte[2] & i_data_byte[3];
                                o_res.warn[3] = i_data_byte[6] & ~i_data_byte[5];
                            end
                            bfd_pkg::KIND_LENGTH: begin
                                o_res.value   = {16'd0, len};
                                o_res.warn[4] = len < ovh16;
                                o_res.warn[5] = (len > bfd_pkg::CRC8_MAX_LEN) & ~r_flags[5];
                                o_res.warn[6] = len <= ovh16;
                                n_plen = plen_calc;
                            end
                            bfd_pkg::KIND_META_CRC: begin
                                o_res.crc     = {24'd0, r_crc8};
                                o_res.warn[7] = i_data_byte != r_crc8;
                            end
                            bfd_pkg::KIND_PAYLOAD: begin
                                o_res.value = {24'd0, i_data_byte};
                                o_res.last  = bytes_new >= r_plen;
                            end
                            bfd_pkg::KIND_END_CRC: begin
                                o_res.crc     = r_flags[5] ? snap_now : {24'd0, r_crc8};
                                o_res.warn[7] = shift_new != o_res.crc;
                            end
                            default: begin
                            end
                        endcase

                        // Move on to the next field once this one is complete.
                        if (o_res.last) begin
                            n_shift = '0;
                            n_bytes = '0;
                            if (r_step >= bfd_pkg::KIND_END_CRC) begin
                                n_done = 1'b1;
                                n_step = '0;
                            end else begin
                                n_step = adv_step;
                            end
                        end
                    end
                end
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= bfd_pkg::MODE_IDLE;
            r_step  <= '0;
            r_bytes <= '0;
            r_shift <= '0;
            r_flags <= '0;
            r_plen  <= '0;
            r_rx_id <= '0;
            r_crc8  <= '0;
            r_crc32 <= bfd_pkg::CRC32_INIT;
            r_snap  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_step  <= n_step;
            r_bytes <= n_bytes;
            r_shift <= n_shift;
            r_flags <= n_flags;
            r_plen  <= n_plen;
            r_rx_id <= n_rx_id;
            r_crc8  <= n_crc8;
            r_crc32 <= n_crc32;
            r_snap  <= n_snap;
            r_done  <= n_done;
        end
    end

endmodule

// File: hdl/bus_frame_field_decoder.sv
// Top level of the bus frame field decoder: input and result registers around the core.
//
// The input channel (i_valid, o_stall, i_action, i_data_byte) carries link events and
// received bytes; one transaction is one event. A frame start clears the frame state,
// data bytes are split into receiver id, header, length, meta CRC8, optional bus ids,
// sender, service and packet ids, payload bytes and the end CRC8 or CRC32. After an
// await-sync event each data byte is reported as an acknowledge byte.
// The output channel (o_valid, i_stall and the o_ field ports) carries at most one
// decoded field for each input transaction; events and bytes inside a multi-byte field
// other than the payload give none.
// A result passes from the input register through the core into the result register.
// Throughput: one transaction per cycle while the receiver does not stall, set by the
// combinational CRC byte update and field decode between the input and result registers.
// When the receiver stalls, the result register holds its transaction and the input
// register holds one more; o_stall rises only when both are full.
// Reset clears the valid bits of both registers, leaves the link idle and the CRC32 at all ones.
module bus_frame_field_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_field_kind,
    output logic [31:0] o_field_value,
    output logic        o_field_last,
    output logic [7:0]  o_warning_mask,
    output logic [31:0] o_computed_crc
);

    logic             r_in_valid;
    logic [1:0]       r_in_action;
    logic [7:0]       r_in_byte;
    logic             r_out_valid;
    bfd_pkg::t_result r_out;
    logic             fire;
    logic             res_valid;
    bfd_pkg::t_result res;

    // The held transaction moves on when the result register is free or being emptied.
    assign fire    = r_in_valid & (~r_out_valid | ~i_stall);
    assign o_stall = r_in_valid & r_out_valid & i_stall;

    bfd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_action    (r_in_action),
        .i_data_byte (r_in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_action <= i_action;
            r_in_byte   <= i_data_byte;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= res_valid;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_field_kind   = r_out.kind;
    assign o_field_value  = r_out.value;
    assign o_field_last   = r_out.last;
    assign o_warning_mask = r_out.warn;
    assign o_computed_crc = r_out.crc;

endmodule

// File: dv/tb_bus_frame_field_decoder.sv
// Self-checking testbench for the bus frame field decoder: frame stimulus, field predictor, checks.
module tb_bus_frame_field_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    // Warning bit positions in the result's warning mask.
    localparam int WARN_ACK_NO_TX    = 0;
    localparam int WARN_ACK_BCAST    = 1;
    localparam int WARN_BOTH_ACKS    = 2;
    localparam int WARN_LEN16_CRC8   = 3;
    localparam int WARN_SHORT_LEN    = 4;
    localparam int WARN_LONG_CRC8    = 5;
    localparam int WARN_NO_PAYLOAD   = 6;
    localparam int WARN_CRC_MISMATCH = 7;

    localparam int RANDOM_ITEMS  = 750;
    localparam int STALL_PERCENT = 15;
    localparam int IDLE_LIMIT    = 4000;
    localparam int REPORT_LIMIT  = 10;

    // One link event as driven on the input channel.
    typedef struct packed {
        logic [1:0] act;
        logic [7:0] data;
    } t_link_event;

    // Predicts the decoded fields and checks them against what the block sends.
    class frame_field_checker;
        bfd_pkg::t_result    awaited_fields[$];
        int                  mismatches;
        int                  fields_checked;
        int                  frames_started;
        int                  ack_fields;
        int                  crc_errors_flagged;

        bfd_pkg::t_link_mode mode;
        logic [3:0]  step;
        logic [15:0] nbytes;
        logic [31:0] shift;
        logic [7:0]  flags;
        logic [15:0] plen;
        logic [7:0]  rxid;
        logic [7:0]  crc8;
        logic [31:0] crc32;
        logic [31:0] snap;
        logic        done;

        function new();
            mismatches = 0;
            fields_checked = 0;
            frames_started = 0;
            ack_fields = 0;
            crc_errors_flagged = 0;
            mode = bfd_pkg::MODE_IDLE;
            clear_frame();
        endfunction

        static function logic [7:0] crc8_next(input logic [7:0] c, input logic [7:0] b);
            logic [7:0] r;
            r = c ^ b;
            repeat (8) r = r[0] ? ((r >> 1) ^ bfd_pkg::CRC8_POLY) : (r >> 1);
            return r;
        endfunction

        static function logic [31:0] crc32_next(input logic [31:0] c, input logic [7:0] b);
            logic [31:0] r;
            r = c ^ {24'd0, b};
            repeat (8) r = r[0] ? ((r >> 1) ^ bfd_pkg::CRC32_POLY) : (r >> 1);
            return r;
        endfunction

        // Bytes of a frame that are not payload, for the given header flags.
        static function logic [15:0] overhead_of(input logic [7:0] f);
            logic [15:0] o;
            o = f[6] ? 16'd5 : 16'd4;
            if (f[0]) o += 16'd4;
            if (f[1]) o += f[0] ? 16'd5 : 16'd1;
            if (f[4]) o += 16'd2;
            if (f[7]) o += 16'd2;
            o += f[5] ? 16'd4 : 16'd1;
            return o;
        endfunction

        function void clear_frame();
            step = bfd_pkg::KIND_RX_ID;
            nbytes = '0;
            shift = '0;
            flags = '0;
            plen = '0;
            rxid = '0;
            crc8 = '0;
            crc32 = bfd_pkg::CRC32_INIT;
            snap = '0;
            done = 1'b0;
        endfunction

        function bit carried(input logic [3:0] s);
            case (s)
                bfd_pkg::KIND_RX_BUS:  return flags[0];
                bfd_pkg::KIND_TX_BUS:  return flags[0] & flags[1];
                bfd_pkg::KIND_TX_ID:   return flags[1];
                bfd_pkg::KIND_SERVICE: return flags[4];
                bfd_pkg::KIND_PACKET:  return flags[7];
                bfd_pkg::KIND_PAYLOAD: return plen != 16'd0;
                default:               return 1'b1;
            endcase
        endfunction

        function logic [15:0] width_of(input logic [3:0] s);
            case (s)
                bfd_pkg::KIND_LENGTH:  return flags[6] ? 16'd2 : 16'd1;
                bfd_pkg::KIND_RX_BUS,
                bfd_pkg::KIND_TX_BUS:  return 16'd4;
                bfd_pkg::KIND_SERVICE,
                bfd_pkg::KIND_PACKET:  return 16'd2;
                bfd_pkg::KIND_END_CRC: return flags[5] ? 16'd4 : 16'd1;
                default:               return 16'd1;
            endcase
        endfunction

        // Step to the next field that the frame carries; the end CRC closes the frame.
        function void move_on();
            logic [3:0] s;
            shift = '0;
            nbytes = '0;
            if (step >= bfd_pkg::KIND_END_CRC) begin
                done = 1'b1;
                step = bfd_pkg::KIND_RX_ID;
            end else begin
                s = step + 4'd1;
                while (s < bfd_pkg::KIND_END_CRC && !carried(s)) s = s + 4'd1;
                step = s;
            end
        endfunction

        // Decode one data byte of a frame that is being collected.
        function void decode_byte(input logic [7:0] b);
            bfd_pkg::t_result r;
            logic [7:0]       prior8;
            logic [15:0]      len;
            logic [15:0]      ovh;
            prior8 = crc8;
            if (step == bfd_pkg::KIND_END_CRC) begin
                if (nbytes == 16'd0) snap = ~crc32;
            end else begin
                crc8 = crc8_next(crc8, b);
                crc32 = crc32_next(crc32, b);
            end
            shift = {shift[23:0], b};
            nbytes = nbytes + 16'd1;
            r.kind = step;
            r.value = shift;
            r.last = 1'b1;
            r.warn = '0;
            r.crc = '0;

            if (step == bfd_pkg::KIND_PAYLOAD) begin
                r.value = {24'd0, b};
                r.last = (nbytes >= plen);
                awaited_fields.push_back(r);
                if (r.last) move_on();
                return;
            end
            if (nbytes < width_of(step)) return;

            case (step)
                bfd_pkg::KIND_RX_ID: rxid = b;
                bfd_pkg::KIND_HEADER: begin
                    flags = b;
                    if ((b[2] | b[3]) && !b[1]) r.warn[WARN_ACK_NO_TX] = 1'b1;
                    if ((b[2] | b[3]) && rxid == 8'd0) r.warn[WARN_ACK_BCAST] = 1'b1;
                    if (b[2] && b[3]) r.warn[WARN_BOTH_ACKS] = 1'b1;
                    if (b[6] && !b[5]) r.warn[WARN_LEN16_CRC8] = 1'b1;
                end
                bfd_pkg::KIND_LENGTH: begin
                    len = flags[6] ? shift[15:0] : {8'd0, shift[7:0]};
                    ovh = overhead_of(flags);
                    r.value = {16'd0, len};
                    if (len < ovh) r.warn[WARN_SHORT_LEN] = 1'b1;
                    if (len > bfd_pkg::CRC8_MAX_LEN && !flags[5])
                        r.warn[WARN_LONG_CRC8] = 1'b1;
                    if (len <= ovh) begin
                        r.warn[WARN_NO_PAYLOAD] = 1'b1;
                        plen = '0;
                    end else begin
                        plen = len - ovh;
                    end
                end
                bfd_pkg::KIND_META_CRC: begin
                    r.crc = {24'd0, prior8};
                    if (b != prior8) r.warn[WARN_CRC_MISMATCH] = 1'b1;
                end
                bfd_pkg::KIND_END_CRC: begin
                    r.crc = flags[5] ? snap : {24'd0, crc8};
                    if (shift != r.crc) r.warn[WARN_CRC_MISMATCH] = 1'b1;
                end
                default: ;
            endcase
            if (r.warn[WARN_CRC_MISMATCH]) crc_errors_flagged++;
            awaited_fields.push_back(r);
            move_on();
        endfunction

        // Note one accepted input transaction.
        function void take_event(input logic [1:0] act, input logic [7:0] b);
            bfd_pkg::t_result r;
            if (act == bfd_pkg::ACT_START) begin
                clear_frame();
                mode = bfd_pkg::MODE_COLLECT;
                frames_started++;
            end else if (act == bfd_pkg::ACT_SYNC) begin
                mode = bfd_pkg::MODE_ACK;
            end else if (act == bfd_pkg::ACT_IDLE) begin
                clear_frame();
                mode = bfd_pkg::MODE_IDLE;
            end else if (mode == bfd_pkg::MODE_ACK) begin
                r.kind = bfd_pkg::KIND_ACK;
                r.value = {24'd0, b};
                r.last = 1'b1;
                r.warn = '0;
                r.crc = '0;
                awaited_fields.push_back(r);
                ack_fields++;
            end else if (mode == bfd_pkg::MODE_COLLECT && !done) begin
                decode_byte(b);
            end
        endfunction

        // Compare one accepted result with the oldest awaited field.
        function void check_field(input bfd_pkg::t_result got);
            bfd_pkg::t_result want;
            if (awaited_fields.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("ERROR: unexpected field kind=%0d value=%h last=%b warn=%h crc=%h",
                             got.kind, got.value, got.last, got.warn, got.crc);
                return;
            end
            want = awaited_fields.pop_front();
            fields_checked++;
            if (got.kind !== want.kind || got.value !== want.value || got.last !== want.last ||
                got.warn !== want.warn || got.crc !== want.crc) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("ERROR: expected kind=%0d value=%h last=%b warn=%h crc=%h",
                             want.kind, want.value, want.last, want.warn, want.crc);
                    $display("       actual   kind=%0d value=%h last=%b warn=%h crc=%h",
                             got.kind, got.value, got.last, got.warn, got.crc);
                end
            end
        endfunction

        function int pending();
            return awaited_fields.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_action;
    logic [7:0]  i_data_byte;
    logic        o_valid;
    logic        i_stall;
    logic [3:0]  o_field_kind;
    logic [31:0] o_field_value;
    logic        o_field_last;
    logic [7:0]  o_warning_mask;
    logic [31:0] o_computed_crc;

    frame_field_checker field_chk;
    t_link_event        stim_q[$];
    logic               gaps_on;
    int                 idle_cycles = 0;
    int                 events_accepted = 0;

    bus_frame_field_decoder u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_data_byte    (i_data_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_field_kind   (o_field_kind),
        .o_field_value  (o_field_value),
        .o_field_last   (o_field_last),
        .o_warning_mask (o_warning_mask),
        .o_computed_crc (o_computed_crc)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Receiver stalls at random while random idling is enabled.
    always @(posedge i_clk) begin
        i_stall <= gaps_on && ($urandom_range(0, 99) < STALL_PERCENT);
    end

    // Check results, note accepted transactions and watch for a hung block.
    always @(posedge i_clk) begin
        bfd_pkg::t_result got;
        got.kind = o_field_kind;
        got.value = o_field_value;
        got.last = o_field_last;
        got.warn = o_warning_mask;
        got.crc = o_computed_crc;
        if (i_rst_n) begin
            if (o_valid && !i_stall) field_chk.check_field(got);
            if (i_valid && !o_stall) begin
                field_chk.take_event(i_action, i_data_byte);
                events_accepted <= events_accepted + 1;
            end
        end
        if ((o_valid && !i_stall) || (i_valid && !o_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("ERROR: no transaction for %0d cycles", IDLE_LIMIT);
            $display("bus_frame_field_decoder: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_event(input logic [1:0] act, input logic [7:0] b);
        t_link_event ev;
        ev.act = act;
        ev.data = b;
        stim_q.push_back(ev);
    endtask

    // Queue a frame start and the frame bytes with meta and end CRCs filled in.
    task automatic queue_frame(input logic [7:0] rx, input logic [7:0] flags,
                               input logic [15:0] len_val, input int pay,
                               input bit bad_meta, input bit bad_end);
        logic [7:0]  body[$];
        logic [7:0]  c8;
        logic [31:0] c32;
        int          extra;
        body.push_back(rx);
        body.push_back(flags);
        if (flags[6]) body.push_back(len_val[15:8]);
        body.push_back(len_val[7:0]);
        c8 = '0;
        foreach (body[i]) c8 = frame_field_checker::crc8_next(c8, body[i]);
        if (bad_meta) c8 = c8 ^ 8'($urandom_range(1, 255));
        body.push_back(c8);

        // Optional ids, then the payload.
        extra = (flags[0] ? 4 : 0) + ((flags[0] && flags[1]) ? 4 : 0) + (flags[1] ? 1 : 0) +
                (flags[4] ? 2 : 0) + (flags[7] ? 2 : 0) + pay;
        repeat (extra) body.push_back(8'($urandom));

        c8 = '0;
        c32 = bfd_pkg::CRC32_INIT;
        foreach (body[i]) begin
            c8 = frame_field_checker::crc8_next(c8, body[i]);
            c32 = frame_field_checker::crc32_next(c32, body[i]);
        end
        c32 = ~c32;
        if (bad_end) begin
            c8 = c8 ^ 8'($urandom_range(1, 255));
            c32 = c32 ^ (32'd1 << $urandom_range(0, 31));
        end
        if (flags[5]) begin
            body.push_back(c32[31:24]);
            body.push_back(c32[23:16]);
            body.push_back(c32[15:8]);
            body.push_back(c32[7:0]);
        end else begin
            body.push_back(c8);
        end

        push_event(bfd_pkg::ACT_START, 8'($urandom));
        foreach (body[i]) push_event(bfd_pkg::ACT_DATA, body[i]);
    endtask

    // Drive one transaction, with a random gap ahead of it when idling is enabled.
    task automatic send_event(input t_link_event ev, input bit use_gaps);
        while (use_gaps && $urandom_range(0, 99) < STALL_PERCENT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= ev.act;
        i_data_byte <= ev.data;
        do @(posedge i_clk); while (o_stall);
    endtask

    initial begin
        int          n_directed;
        int          pick;
        int          pay;
        logic [7:0]  flags;
        logic [7:0]  rx;
        logic [15:0] len_val;

        field_chk = new();
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_action <= bfd_pkg::ACT_IDLE;
        i_data_byte <= '0;
        gaps_on <= 1'b1;

        // Directed: data while idle, broadcast frame asking both acks with no payload,
        // a byte after the end CRC, acknowledge bytes, data after idle, and a 16-bit
        // length shorter than the overhead with a wrong meta CRC.
        push_event(bfd_pkg::ACT_DATA, 8'h5a);
        queue_frame(8'h00, 8'h0c, 16'd5, 0, 1'b0, 1'b0);
        push_event(bfd_pkg::ACT_DATA, 8'hff);
        push_event(bfd_pkg::ACT_SYNC, 8'h00);
        push_event(bfd_pkg::ACT_DATA, 8'hff);
        push_event(bfd_pkg::ACT_DATA, 8'h00);
        push_event(bfd_pkg::ACT_IDLE, 8'hff);
        push_event(bfd_pkg::ACT_DATA, 8'ha5);
        queue_frame(8'hff, 8'h40, 16'd2, 0, 1'b1, 1'b0);
        n_directed = stim_q.size();

        // Random: mostly well-formed frames, some with bad lengths, acks and noise.
        while (stim_q.size() < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            flags = 8'($urandom);
            rx = ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom);
            if (pick < 70) begin
                pay = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                                   : $urandom_range(0, 12);
                len_val = frame_field_checker::overhead_of(flags) + 16'(pay);
                queue_frame(rx, flags, len_val, pay, $urandom_range(0, 9) == 0,
                            $urandom_range(0, 9) == 0);
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 3))
                        push_event(bfd_pkg::ACT_DATA, 8'($urandom));
            end else if (pick < 80) begin
                len_val = flags[6] ? 16'($urandom) : {8'd0, 8'($urandom)};
                queue_frame(rx, flags, len_val, $urandom_range(0, 15),
                            $urandom_range(0, 1), $urandom_range(0, 1));
            end else if (pick < 90) begin
                push_event(bfd_pkg::ACT_SYNC, 8'($urandom));
                repeat ($urandom_range(1, 6)) push_event(bfd_pkg::ACT_DATA, 8'($urandom));
                if ($urandom_range(0, 1)) push_event(bfd_pkg::ACT_IDLE, 8'($urandom));
            end else begin
                repeat ($urandom_range(4, 12))
                    push_event(2'($urandom_range(0, 3)), 8'($urandom));
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Drive everything; one stretch of random transactions runs with no idling.
        foreach (stim_q[i]) begin
            gaps_on <= !(i >= n_directed + 250 && i < n_directed + 400);
            send_event(stim_q[i], !(i >= n_directed + 250 && i < n_directed + 400));
        end
        i_valid <= 1'b0;
        gaps_on <= 1'b1;

        while (field_chk.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("Run: %0d transactions in, %0d fields checked, %0d frames started.",
                 events_accepted, field_chk.fields_checked, field_chk.frames_started);
        $display("Run: %0d ack fields, %0d CRC errors flagged, %0d mismatches.",
                 field_chk.ack_fields, field_chk.crc_errors_flagged, field_chk.mismatches);
        if (field_chk.mismatches == 0 && field_chk.pending() == 0) begin
            $display("bus_frame_field_decoder: match");
        end else begin
            $display("bus_frame_field_decoder: mismatch");
        end
        $finish;
    end

endmodule
